// ----- rtl/cpt_pkg.sv -----
// Shared widths, types and helpers of the closest-point-on-triangle pipeline
`timescale 1ns / 1ps
package cpt_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int DOT_W       = PROD_W + 2;
    localparam int DOT_LO_W    = DOT_W / 2;
    localparam int DOT_HI_W    = DOT_W - DOT_LO_W;
    localparam int HL_W        = DOT_W + 1;
    localparam int PRD_W       = 2 * DOT_W;
    localparam int CROSS_W     = PRD_W + 1;
    localparam int TDIF_W      = DOT_W + 1;
    localparam int DEN_W       = CROSS_W + 2;
    localparam int SCL_LO_W    = (CROSS_W + 3) / 4;
    localparam int CHK_W       = SCL_LO_W + 1;
    localparam int SPP_W       = CHK_W + DIFF_W;
    localparam int NUM_W       = CROSS_W + DIFF_W + 1;
    localparam int QUO_W       = COORD_WIDTH + 2;
    localparam int TRY_W       = DEN_W + QUO_W + 1;
    localparam int SUM_W       = QUO_W + 2;

    localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        REGION_A  = 3'd0,
        REGION_B  = 3'd1,
        REGION_C  = 3'd2,
        REGION_AB = 3'd3,
        REGION_AC = 3'd4,
        REGION_BC = 3'd5,
        REGION_IN = 3'd6
    } region_t;

    typedef logic [2:0][COORD_WIDTH-1:0] vec_t;
    typedef logic [2:0][DIFF_W-1:0]      dvec_t;
    typedef logic [5:0][DOT_W-1:0]       dots_t;

    typedef struct packed {
        vec_t  a;
        vec_t  b;
        vec_t  c;
        dvec_t ab;
        dvec_t ac;
        dvec_t bc;
    } geom_t;

    typedef struct packed {
        region_t              region;
        logic                 direct;
        vec_t                 base;
        logic [CROSS_W-1:0]   s1;
        logic [CROSS_W-1:0]   s2;
        logic [DEN_W-1:0]     den;
        dvec_t                e1;
        dvec_t                e2;
    } sel_t;

    typedef struct packed {
        region_t                   region;
        logic                      direct;
        vec_t                      base;
        logic [2:0]                neg;
        logic [2:0][NUM_W-1:0]     mag;
        logic [DEN_W-1:0]          dmag;
    } div_t;

    typedef struct packed {
        region_t region;
        vec_t    near;
    } res_t;

    // Difference of two coordinates, one bit wider
    function automatic logic [DIFF_W-1:0] coord_sub(
        input logic [COORD_WIDTH-1:0] x,
        input logic [COORD_WIDTH-1:0] y
    );
        return {x[COORD_WIDTH-1], x} - {y[COORD_WIDTH-1], y};
    endfunction

endpackage

// ----- rtl/cpt_ifs.sv -----
// Query and result channel interfaces
`timescale 1ns / 1ps
interface cpt_query_if import cpt_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] point_x;
    logic [COORD_WIDTH-1:0] point_y;
    logic [COORD_WIDTH-1:0] point_z;
    logic [COORD_WIDTH-1:0] vert_a_x;
    logic [COORD_WIDTH-1:0] vert_a_y;
    logic [COORD_WIDTH-1:0] vert_a_z;
    logic [COORD_WIDTH-1:0] vert_b_x;
    logic [COORD_WIDTH-1:0] vert_b_y;
    logic [COORD_WIDTH-1:0] vert_b_z;
    logic [COORD_WIDTH-1:0] vert_c_x;
    logic [COORD_WIDTH-1:0] vert_c_y;
    logic [COORD_WIDTH-1:0] vert_c_z;

    modport source (
        output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
        output vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
        input  vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
        output ready
    );
endinterface

interface cpt_result_if import cpt_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] near_x;
    logic [COORD_WIDTH-1:0] near_y;
    logic [COORD_WIDTH-1:0] near_z;
    logic [2:0]             region;

    modport source (output valid, near_x, near_y, near_z, region, input ready);
    modport sink (input valid, near_x, near_y, near_z, region, output ready);
endinterface

// ----- rtl/cpt_dot.sv -----
// Edge vectors and the six dot products, three register stages
`timescale 1ns / 1ps
module cpt_dot import cpt_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  vec_t  p,
    input  vec_t  a,
    input  vec_t  b,
    input  vec_t  c,
    output logic  out_valid,
    output geom_t geom,
    output dots_t dots
);

    logic  s1_v_reg;
    logic  s2_v_reg;
    logic  s3_v_reg;
    geom_t s1_geom_reg;
    geom_t s2_geom_reg;
    geom_t s3_geom_reg;
    dvec_t ap_reg;
    dvec_t bp_reg;
    dvec_t cp_reg;
    dots_t dots_reg;
    logic signed [PROD_W-1:0] prod_reg [6][3];
    dvec_t rhs [3];

    assign rhs[0] = ap_reg;
    assign rhs[1] = bp_reg;
    assign rhs[2] = cp_reg;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    // Stage 1: differences; stage 2: products; stage 3: sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_geom_reg.a <= a;
            s1_geom_reg.b <= b;
            s1_geom_reg.c <= c;
            for (int i = 0; i < 3; i++)
            begin
                s1_geom_reg.ab[i] <= coord_sub(b[i], a[i]);
                s1_geom_reg.ac[i] <= coord_sub(c[i], a[i]);
                s1_geom_reg.bc[i] <= coord_sub(c[i], b[i]);
                ap_reg[i]         <= coord_sub(p[i], a[i]);
                bp_reg[i]         <= coord_sub(p[i], b[i]);
                cp_reg[i]         <= coord_sub(p[i], c[i]);
            end
            s2_geom_reg <= s1_geom_reg;
            for (int k = 0; k < 6; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (k % 2 == 0)
                        prod_reg[k][i] <= $signed(s1_geom_reg.ab[i]) * $signed(rhs[k/2][i]);
                    else
                        prod_reg[k][i] <= $signed(s1_geom_reg.ac[i]) * $signed(rhs[k/2][i]);
                end
            end
            s3_geom_reg <= s2_geom_reg;
            for (int k = 0; k < 6; k++)
                dots_reg[k] <= DOT_W'(prod_reg[k][0]) + DOT_W'(prod_reg[k][1])
                             + DOT_W'(prod_reg[k][2]);
        end
    end

    assign out_valid = s3_v_reg;
    assign geom      = s3_geom_reg;
    assign dots      = dots_reg;

endmodule

// ----- rtl/cpt_cross.sv -----
// Cross terms, region tests and weight selection, four register stages
`timescale 1ns / 1ps
module cpt_cross import cpt_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  geom_t geom,
    input  dots_t dots,
    output logic  out_valid,
    output sel_t  sel
);

    // Operand pairs of the six cross products, indexes into the dot list
    localparam int PL [6] = '{0, 2, 4, 0, 2, 4};
    localparam int PR [6] = '{3, 1, 1, 5, 5, 3};

    logic [3:0] v_reg;
    geom_t s4_geom_reg;
    geom_t s5_geom_reg;
    geom_t s6_geom_reg;
    dots_t s4_dots_reg;
    dots_t s5_dots_reg;
    dots_t s6_dots_reg;
    logic signed [2*DOT_HI_W-1:0] hh_reg [6];
    logic signed [HL_W-1:0]       hl_reg [6];
    logic signed [HL_W-1:0]       lh_reg [6];
    logic [2*DOT_LO_W-1:0]        ll_reg [6];
    logic signed [PRD_W-1:0]      prd_reg [6];
    logic signed [CROSS_W-1:0]    va_reg;
    logic signed [CROSS_W-1:0]    vb_reg;
    logic signed [CROSS_W-1:0]    vc_reg;
    logic signed [TDIF_W-1:0]     t1_reg;
    logic signed [TDIF_W-1:0]     t2_reg;
    logic signed [TDIF_W-1:0]     dab_reg;
    logic signed [TDIF_W-1:0]     dac_reg;
    sel_t sel_reg;
    sel_t sel_next;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[2:0], in_valid};
    end

    // Stage 4: partial products; stage 5: full products; stage 6: differences
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_geom_reg <= geom;
            s4_dots_reg <= dots;
            for (int m = 0; m < 6; m++)
            begin
                hh_reg[m] <= $signed(dots[PL[m]][DOT_W-1:DOT_LO_W])
                           * $signed(dots[PR[m]][DOT_W-1:DOT_LO_W]);
                hl_reg[m] <= $signed(dots[PL[m]][DOT_W-1:DOT_LO_W])
                           * $signed({1'b0, dots[PR[m]][DOT_LO_W-1:0]});
                lh_reg[m] <= $signed(dots[PR[m]][DOT_W-1:DOT_LO_W])
                           * $signed({1'b0, dots[PL[m]][DOT_LO_W-1:0]});
                ll_reg[m] <= dots[PL[m]][DOT_LO_W-1:0] * dots[PR[m]][DOT_LO_W-1:0];
            end
            s5_geom_reg <= s4_geom_reg;
            s5_dots_reg <= s4_dots_reg;
            for (int m = 0; m < 6; m++)
                prd_reg[m] <= (PRD_W'(hh_reg[m]) << (2 * DOT_LO_W))
                            + ((PRD_W'(hl_reg[m]) + PRD_W'(lh_reg[m])) << DOT_LO_W)
                            + PRD_W'(ll_reg[m]);
            s6_geom_reg <= s5_geom_reg;
            s6_dots_reg <= s5_dots_reg;
            vc_reg  <= CROSS_W'(prd_reg[0]) - CROSS_W'(prd_reg[1]);
            vb_reg  <= CROSS_W'(prd_reg[2]) - CROSS_W'(prd_reg[3]);
            va_reg  <= CROSS_W'(prd_reg[4]) - CROSS_W'(prd_reg[5]);
            t1_reg  <= TDIF_W'($signed(s5_dots_reg[3])) - TDIF_W'($signed(s5_dots_reg[2]));
            t2_reg  <= TDIF_W'($signed(s5_dots_reg[4])) - TDIF_W'($signed(s5_dots_reg[5]));
            dab_reg <= TDIF_W'($signed(s5_dots_reg[0])) - TDIF_W'($signed(s5_dots_reg[2]));
            dac_reg <= TDIF_W'($signed(s5_dots_reg[1])) - TDIF_W'($signed(s5_dots_reg[5]));
        end
    end

    // Stage 7: pick the region in test order and its weights
    always_comb
    begin
        logic d1_le0, d2_le0, d3_le0, d6_le0;
        logic t1_le0, t2_le0, va_le0, vb_le0, vc_le0;
        logic signed [DEN_W-1:0] den_in;
        d1_le0 = s6_dots_reg[0][DOT_W-1] || (s6_dots_reg[0] == '0);
        d2_le0 = s6_dots_reg[1][DOT_W-1] || (s6_dots_reg[1] == '0);
        d3_le0 = s6_dots_reg[2][DOT_W-1] || (s6_dots_reg[2] == '0);
        d6_le0 = s6_dots_reg[5][DOT_W-1] || (s6_dots_reg[5] == '0);
        t1_le0 = t1_reg[TDIF_W-1] || (t1_reg == '0);
        t2_le0 = t2_reg[TDIF_W-1] || (t2_reg == '0);
        va_le0 = va_reg[CROSS_W-1] || (va_reg == '0);
        vb_le0 = vb_reg[CROSS_W-1] || (vb_reg == '0);
        vc_le0 = vc_reg[CROSS_W-1] || (vc_reg == '0);
        den_in = DEN_W'(va_reg) + DEN_W'(vb_reg) + DEN_W'(vc_reg);

        sel_next.region = REGION_IN;
        sel_next.direct = 1'b0;
        sel_next.base   = s6_geom_reg.a;
        sel_next.s1     = vb_reg;
        sel_next.s2     = vc_reg;
        sel_next.den    = den_in;
        sel_next.e1     = s6_geom_reg.ab;
        sel_next.e2     = s6_geom_reg.ac;

        priority if (d1_le0 && d2_le0)
        begin
            sel_next.region = REGION_A;
            sel_next.direct = 1'b1;
        end
        else if (!s6_dots_reg[2][DOT_W-1] && t1_le0)
        begin
            sel_next.region = REGION_B;
            sel_next.direct = 1'b1;
            sel_next.base   = s6_geom_reg.b;
        end
        else if (vc_le0 && !s6_dots_reg[0][DOT_W-1] && d3_le0)
        begin
            sel_next.region = REGION_AB;
            sel_next.s1     = CROSS_W'($signed(s6_dots_reg[0]));
            sel_next.s2     = '0;
            sel_next.den    = DEN_W'(dab_reg);
        end
        else if (!s6_dots_reg[5][DOT_W-1] && t2_le0)
        begin
            sel_next.region = REGION_C;
            sel_next.direct = 1'b1;
            sel_next.base   = s6_geom_reg.c;
        end
        else if (vb_le0 && !s6_dots_reg[1][DOT_W-1] && d6_le0)
        begin
            sel_next.region = REGION_AC;
            sel_next.s1     = CROSS_W'($signed(s6_dots_reg[1]));
            sel_next.s2     = '0;
            sel_next.den    = DEN_W'(dac_reg);
            sel_next.e1     = s6_geom_reg.ac;
        end
        else if (va_le0 && !t1_reg[TDIF_W-1] && !t2_reg[TDIF_W-1])
        begin
            sel_next.region = REGION_BC;
            sel_next.base   = s6_geom_reg.b;
            sel_next.s1     = CROSS_W'(t1_reg);
            sel_next.s2     = '0;
            sel_next.den    = DEN_W'(t1_reg) + DEN_W'(t2_reg);
            sel_next.e1     = s6_geom_reg.bc;
        end
        else
        begin
            sel_next.region = REGION_IN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sel_reg <= sel_next;
    end

    assign out_valid = v_reg[3];
    assign sel       = sel_reg;

endmodule

// ----- rtl/cpt_combo.sv -----
// Weighted edge sums per coordinate and their magnitudes, four register stages
`timescale 1ns / 1ps
module cpt_combo import cpt_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  sel_t sel,
    output logic out_valid,
    output div_t dq
);

    typedef struct packed {
        region_t          region;
        logic             direct;
        vec_t             base;
        logic             dneg;
        logic [DEN_W-1:0] dmag;
    } side_t;

    logic [3:0] v_reg;
    side_t s8_side_reg;
    side_t s9_side_reg;
    side_t s10_side_reg;
    logic [1:0][CROSS_W-1:0] sv;
    dvec_t ev [2];
    logic signed [CHK_W-1:0] chk [2][4];
    logic signed [SPP_W-1:0] pp_reg [2][3][4];
    logic signed [NUM_W-1:0] term_next [2][3];
    logic signed [NUM_W-1:0] term_reg [2][3];
    logic signed [NUM_W-1:0] x_reg [3];
    div_t dq_reg;
    logic den_neg;

    assign sv      = {sel.s2, sel.s1};
    assign ev[0]   = sel.e1;
    assign ev[1]   = sel.e2;
    assign den_neg = sel.den[DEN_W-1];

    // Cut each weight into chunks, the top one signed
    always_comb
    begin
        for (int t = 0; t < 2; t++)
        begin
            for (int k = 0; k < 3; k++)
                chk[t][k] = $signed({1'b0, sv[t][k*SCL_LO_W +: SCL_LO_W]});
            chk[t][3] = CHK_W'($signed(sv[t][CROSS_W-1:3*SCL_LO_W]));
        end
    end

    // Add the shifted chunk products of each term
    always_comb
    begin
        for (int t = 0; t < 2; t++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                term_next[t][i] = '0;
                for (int k = 0; k < 4; k++)
                    term_next[t][i] = term_next[t][i]
                                    + (NUM_W'(pp_reg[t][i][k]) << (k * SCL_LO_W));
            end
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[2:0], in_valid};
    end

    // Stage 8: chunk products; 9: term sums; 10: numerator; 11: magnitude
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_side_reg.region <= sel.region;
            s8_side_reg.direct <= sel.direct || (sel.den == '0);
            s8_side_reg.base   <= sel.base;
            s8_side_reg.dneg   <= den_neg;
            s8_side_reg.dmag   <= den_neg ? (~sel.den + 1'b1) : sel.den;
            for (int t = 0; t < 2; t++)
                for (int i = 0; i < 3; i++)
                    for (int k = 0; k < 4; k++)
                        pp_reg[t][i][k] <= chk[t][k] * $signed(ev[t][i]);
            s9_side_reg <= s8_side_reg;
            term_reg    <= term_next;
            s10_side_reg <= s9_side_reg;
            for (int i = 0; i < 3; i++)
                x_reg[i] <= term_reg[0][i] + term_reg[1][i];
            dq_reg.region <= s10_side_reg.region;
            dq_reg.direct <= s10_side_reg.direct;
            dq_reg.base   <= s10_side_reg.base;
            dq_reg.dmag   <= s10_side_reg.dmag;
            for (int i = 0; i < 3; i++)
            begin
                dq_reg.neg[i] <= x_reg[i][NUM_W-1] ^ s10_side_reg.dneg;
                dq_reg.mag[i] <= x_reg[i][NUM_W-1] ? (~x_reg[i] + 1'b1) : x_reg[i];
            end
        end
    end

    assign out_valid = v_reg[3];
    assign dq        = dq_reg;

endmodule

// ----- rtl/cpt_div.sv -----
// Pipelined restoring divider, three lanes, one quotient bit per stage
`timescale 1ns / 1ps
module cpt_div import cpt_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  div_t dq,
    output logic out_valid,
    output res_t res
);

    typedef struct packed {
        region_t               region;
        logic                  direct;
        vec_t                  base;
        logic [2:0]            neg;
        logic [2:0]            ovf;
        logic [2:0][NUM_W-1:0] rem;
        logic [2:0][QUO_W-1:0] quo;
        logic [DEN_W-1:0]      dmag;
    } dstage_t;

    logic [QUO_W:0] v_reg;
    dstage_t st_reg  [QUO_W+1];
    dstage_t st_next [QUO_W+1];
    logic res_v_reg;
    res_t res_reg;
    res_t res_next;

    // Entry: flag quotients too large to fit; each stage: trial subtract
    always_comb
    begin
        logic [TRY_W-1:0] dsh;
        logic [TRY_W-1:0] rx;
        logic             ge;
        st_next[0].region = dq.region;
        st_next[0].direct = dq.direct;
        st_next[0].base   = dq.base;
        st_next[0].neg    = dq.neg;
        st_next[0].rem    = dq.mag;
        st_next[0].quo    = '0;
        st_next[0].dmag   = dq.dmag;
        for (int i = 0; i < 3; i++)
            st_next[0].ovf[i] = TRY_W'(dq.mag[i]) >= (TRY_W'(dq.dmag) << QUO_W);
        for (int j = 1; j <= QUO_W; j++)
        begin
            st_next[j] = st_reg[j-1];
            for (int i = 0; i < 3; i++)
            begin
                dsh = TRY_W'(st_reg[j-1].dmag) << (QUO_W - j);
                rx  = TRY_W'(st_reg[j-1].rem[i]);
                ge  = rx >= dsh;
                if (ge)
                    st_next[j].rem[i] = NUM_W'(rx - dsh);
                st_next[j].quo[i][QUO_W-j] = ge;
            end
        end
    end

    // Final: add to base unless direct, truncate toward zero, saturate
    always_comb
    begin
        logic signed [SUM_W-1:0] base_e;
        logic signed [SUM_W-1:0] q_e;
        logic signed [SUM_W-1:0] t;
        logic signed [SUM_W-1:0] r;
        logic                    frac;
        res_next.region = st_reg[QUO_W].region;
        res_next.near   = st_reg[QUO_W].base;
        for (int i = 0; i < 3; i++)
        begin
            base_e = SUM_W'($signed(st_reg[QUO_W].base[i]));
            q_e    = $signed(SUM_W'(st_reg[QUO_W].quo[i]));
            frac   = |st_reg[QUO_W].rem[i];
            t      = st_reg[QUO_W].neg[i] ? (base_e - q_e) : (base_e + q_e);
            if (!st_reg[QUO_W].neg[i] && t[SUM_W-1] && frac)
                r = t + SUM_W'(1);
            else if (st_reg[QUO_W].neg[i] && !t[SUM_W-1] && (t != '0) && frac)
                r = t - SUM_W'(1);
            else
                r = t;
            priority if (st_reg[QUO_W].direct)
                res_next.near[i] = st_reg[QUO_W].base[i];
            else if (st_reg[QUO_W].ovf[i])
                res_next.near[i] = st_reg[QUO_W].neg[i] ? COORD_MIN : COORD_MAX;
            else if (r > SUM_W'($signed(COORD_MAX)))
                res_next.near[i] = COORD_MAX;
            else if (r < SUM_W'($signed(COORD_MIN)))
                res_next.near[i] = COORD_MIN;
            else
                res_next.near[i] = r[COORD_WIDTH-1:0];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            res_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg     <= {v_reg[QUO_W-1:0], in_valid};
            res_v_reg <= v_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j <= QUO_W; j++)
                st_reg[j] <= st_next[j];
            res_reg <= res_next;
        end
    end

    assign out_valid = res_v_reg;
    assign res       = res_reg;

endmodule

// ----- rtl/closest_point_on_triangle.sv -----
// Throughput: one query per cycle while the skid register is empty; the pipeline is 39
// stages deep plus the output register, of which 28 belong to the divider: an entry
// stage, 26 stages that each yield one quotient bit, and a final rounding stage.
// A result waiting at the output does not block input: a skid register holds one more.
// Reset: asynchronous, active low; clears all valid bits, data registers keep content.
`timescale 1ns / 1ps
module closest_point_on_triangle import cpt_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    cpt_query_if.sink   query,
    cpt_result_if.source result
);

    logic  en;
    vec_t  p, a, b, c;
    logic  dot_v, cross_v, combo_v, pipe_v;
    geom_t geom;
    dots_t dots;
    sel_t  sel;
    div_t  dq;
    res_t  pipe_res;
    logic  out_v_reg;
    logic  skid_v_reg;
    res_t  out_res_reg;
    res_t  skid_res_reg;

    // Whole pipe advances unless the skid register is occupied
    assign en          = !skid_v_reg;
    assign query.ready = en;

    assign p = {query.point_z, query.point_y, query.point_x};
    assign a = {query.vert_a_z, query.vert_a_y, query.vert_a_x};
    assign b = {query.vert_b_z, query.vert_b_y, query.vert_b_x};
    assign c = {query.vert_c_z, query.vert_c_y, query.vert_c_x};

    cpt_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (query.valid),
        .p         (p),
        .a         (a),
        .b         (b),
        .c         (c),
        .out_valid (dot_v),
        .geom      (geom),
        .dots      (dots)
    );

    cpt_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dot_v),
        .geom      (geom),
        .dots      (dots),
        .out_valid (cross_v),
        .sel       (sel)
    );

    cpt_combo u_combo (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cross_v),
        .sel       (sel),
        .out_valid (combo_v),
        .dq        (dq)
    );

    cpt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (combo_v),
        .dq        (dq),
        .out_valid (pipe_v),
        .res       (pipe_res)
    );

    // Output register with skid: refill from skid first, else from the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || result.ready)
        begin
            out_v_reg  <= skid_v_reg || pipe_v;
            skid_v_reg <= 1'b0;
        end
        else if (pipe_v && !skid_v_reg)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || result.ready)
            out_res_reg <= skid_v_reg ? skid_res_reg : pipe_res;
        if (out_v_reg && !result.ready && !skid_v_reg)
            skid_res_reg <= pipe_res;
    end

    assign result.valid  = out_v_reg;
    assign result.near_x = out_res_reg.near[0];
    assign result.near_y = out_res_reg.near[1];
    assign result.near_z = out_res_reg.near[2];
    assign result.region = out_res_reg.region;

    // Skid holds a result only behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid register full with output empty");

    // Skid fills only when the output was stalled
    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && !result.ready))
        else $error("skid register filled without a stall");

    // A finished item leaving the pipe is never dropped
    a_pipe_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_v && en) |=> out_v_reg)
        else $error("pipe result lost at the output");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the closest-point-on-triangle pipeline
`timescale 1ns / 1ps
module tb_top;
    import cpt_pkg::*;

    typedef logic signed [191:0] wide_t;
    typedef wide_t wvec_t [3];

    typedef struct {
        vec_t p;
        vec_t a;
        vec_t b;
        vec_t c;
    } query_t;

    typedef struct {
        vec_t    near;
        region_t region;
    } nearest_t;

    localparam int RANDOM_QUERIES = 1530;

    logic clk;
    logic rst_n;

    cpt_query_if  query ();
    cpt_result_if result ();

    closest_point_on_triangle dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query.sink),
        .result (result.source)
    );

    query_t   pending_queries [$];
    nearest_t expected_points [$];
    int       error_count;
    int       queries_sent;
    int       results_seen;
    bit       query_taken;
    bit       result_taken;
    bit       long_hold;
    bit       burst_mode;
    int       send_gap;
    int       recv_gap;

    // Sign-extend a coordinate to full width
    function automatic wide_t widen(input logic [COORD_WIDTH-1:0] x);
        wide_t r;
        r = $signed(x);
        return r;
    endfunction

    // Clamp to the signed coordinate range
    function automatic logic [COORD_WIDTH-1:0] clamp_coord(input wide_t v);
        wide_t hi;
        wide_t lo;
        hi = widen(COORD_MAX);
        lo = widen(COORD_MIN);
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return v[COORD_WIDTH-1:0];
    endfunction

    function automatic wide_t dot3(input wvec_t u, input wvec_t v);
        return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    function automatic wvec_t diff3(input wvec_t u, input wvec_t v);
        wvec_t r;
        for (int i = 0; i < 3; i++)
            r[i] = u[i] - v[i];
        return r;
    endfunction

    function automatic nearest_t vertex_point(input wvec_t v, input region_t rg);
        nearest_t r;
        for (int i = 0; i < 3; i++)
            r.near[i] = clamp_coord(v[i]);
        r.region = rg;
        return r;
    endfunction

    // Exact rational blend (base*den + s1*e1 + s2*e2) / den, truncated
    function automatic nearest_t blend_point(input wvec_t base, input wide_t s1,
                                             input wvec_t e1, input wide_t s2,
                                             input wvec_t e2, input wide_t den,
                                             input region_t rg);
        wvec_t r;
        if (den == 0)
            return vertex_point(base, rg);
        for (int i = 0; i < 3; i++)
            r[i] = (base[i] * den + s1 * e1[i] + s2 * e2[i]) / den;
        return vertex_point(r, rg);
    endfunction

    // Voronoi-region classification of the query point
    function automatic nearest_t nearest_on_triangle(input query_t q);
        wvec_t p, a, b, c, ab, ac, ap, bp, cp, bc, zv;
        wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, t1, t2;
        for (int i = 0; i < 3; i++)
        begin
            p[i]  = widen(q.p[i]);
            a[i]  = widen(q.a[i]);
            b[i]  = widen(q.b[i]);
            c[i]  = widen(q.c[i]);
            zv[i] = '0;
        end
        ab = diff3(b, a);
        ac = diff3(c, a);
        ap = diff3(p, a);
        d1 = dot3(ab, ap);
        d2 = dot3(ac, ap);
        if (d1 <= 0 && d2 <= 0)
            return vertex_point(a, REGION_A);
        bp = diff3(p, b);
        d3 = dot3(ab, bp);
        d4 = dot3(ac, bp);
        if (d3 >= 0 && d4 <= d3)
            return vertex_point(b, REGION_B);
        vc = d1 * d4 - d3 * d2;
        if (vc <= 0 && d1 >= 0 && d3 <= 0)
            return blend_point(a, d1, ab, 0, zv, d1 - d3, REGION_AB);
        cp = diff3(p, c);
        d5 = dot3(ab, cp);
        d6 = dot3(ac, cp);
        if (d6 >= 0 && d5 <= d6)
            return vertex_point(c, REGION_C);
        vb = d5 * d2 - d1 * d6;
        if (vb <= 0 && d2 >= 0 && d6 <= 0)
            return blend_point(a, d2, ac, 0, zv, d2 - d6, REGION_AC);
        va = d3 * d6 - d5 * d4;
        t1 = d4 - d3;
        t2 = d5 - d6;
        if (va <= 0 && t1 >= 0 && t2 >= 0)
        begin
            bc = diff3(c, b);
            return blend_point(b, t1, bc, 0, zv, t1 + t2, REGION_BC);
        end
        return blend_point(a, vb, ab, vc, ac, va + vb + vc, REGION_IN);
    endfunction

    task automatic add_query(input int px, input int py, input int pz,
                             input int ax, input int ay, input int az,
                             input int bx, input int by, input int bz,
                             input int cx, input int cy, input int cz);
        query_t q;
        q.p = {pz[COORD_WIDTH-1:0], py[COORD_WIDTH-1:0], px[COORD_WIDTH-1:0]};
        q.a = {az[COORD_WIDTH-1:0], ay[COORD_WIDTH-1:0], ax[COORD_WIDTH-1:0]};
        q.b = {bz[COORD_WIDTH-1:0], by[COORD_WIDTH-1:0], bx[COORD_WIDTH-1:0]};
        q.c = {cz[COORD_WIDTH-1:0], cy[COORD_WIDTH-1:0], cx[COORD_WIDTH-1:0]};
        pending_queries.push_back(q);
    endtask

    // Coordinate near a center, spread by 2^span
    function automatic int near_coord(input int center, input int span);
        int off;
        off = int'($urandom_range(0, (1 << (span + 1)) - 1)) - (1 << span);
        return center + off;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Safety limit
    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus
    initial
    begin
        int mx, mn, s, span, cx0, cy0, cz0;
        mx = 8388607;
        mn = -8388608;
        s  = 4096;
        // one query per region on a right triangle of leg s, and one on its mirror
        add_query(-100, -100, 0,   0, 0, 0,   s, 0, 0,   0, s, 0);
        add_query(2*s, -50, 7,     0, 0, 0,   s, 0, 0,   0, s, 0);
        add_query(-50, 2*s, -7,    0, 0, 0,   s, 0, 0,   0, s, 0);
        add_query(s/3, -500, 300,  0, 0, 0,   s, 0, 0,   0, s, 0);
        add_query(-500, s/3, -300, 0, 0, 0,   s, 0, 0,   0, s, 0);
        add_query(s, s, 123,       0, 0, 0,   s, 0, 0,   0, s, 0);
        add_query(s/5, s/7, -999,  0, 0, 0,   s, 0, 0,   0, s, 0);
        add_query(-s/5, -s/7, 999, 0, 0, 0,   -s, 0, 0,  0, -s, 0);
        // degenerate triangles: a point and collinear vertices
        add_query(5, 6, 7,         1, 1, 1,   1, 1, 1,   1, 1, 1);
        add_query(s, s, 0,         0, 0, 0,   s, s, 0,   2*s, 2*s, 0);
        add_query(s, -s, 0,        0, 0, 0,   2*s, 0, 0, s, 0, 0);
        add_query(s, 5, 0,         0, 0, 0,   2*s, 0, 0, 2*s, 0, 0);
        add_query(3*s, 3*s, 3*s,   0, 0, 0,   2*s, 0, 0, 2*s, 0, 0);
        // coordinate extremes
        add_query(mx, mx, mx,      mx, mx, mx, mx, mx, mx, mx, mx, mx);
        add_query(mn, mn, mn,      mn, mn, mn, mn, mn, mn, mn, mn, mn);
        add_query(mx, mn, mx,      mn, mx, mn, mx, mx, mn, mn, mn, mx);
        add_query(mn, mx, mn,      mx, mn, mx, mn, mn, mx, mx, mx, mn);
        add_query(0, 0, 0,         mn, mn, 0, mx, mn, 0, 0, mx, 0);
        add_query(0, 0, mx,        mn, mn, 0, mx, mn, 0, 0, mx, 0);
        add_query(mx, mx, 0,       mn, 0, 0, 0, mn, 0, mx, mx, mn);
        add_query(0, 0, 0,         0, 0, 0,   0, 0, 0,   0, 0, 0);
        // random: mostly compact triangles near the point, some anywhere
        for (int n = 0; n < RANDOM_QUERIES; n++)
        begin
            if ($urandom_range(0, 3) == 0)
                add_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
            begin
                span = $urandom_range(2, 20);
                cx0  = $signed($urandom_range(0, 16777215) - 8388608) / 2;
                cy0  = $signed($urandom_range(0, 16777215) - 8388608) / 2;
                cz0  = $signed($urandom_range(0, 16777215) - 8388608) / 2;
                add_query(near_coord(cx0, span), near_coord(cy0, span),
                          near_coord(cz0, span), near_coord(cx0, span),
                          near_coord(cy0, span), near_coord(cz0, span),
                          near_coord(cx0, span), near_coord(cy0, span),
                          near_coord(cz0, span), near_coord(cx0, span),
                          near_coord(cy0, span), near_coord(cz0, span));
            end
        end
    end

    // Reset and end of run
    initial
    begin
        int total;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_queries.size() > 0);
        total = pending_queries.size();
        wait (queries_sent == total && expected_points.size() == 0);
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Query driver: hold each item until its transfer, random idle gaps (maybe none) between items
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query.valid <= 1'b0;
            query.point_x <= '0;  query.point_y <= '0;  query.point_z <= '0;
            query.vert_a_x <= '0; query.vert_a_y <= '0; query.vert_a_z <= '0;
            query.vert_b_x <= '0; query.vert_b_y <= '0; query.vert_b_z <= '0;
            query.vert_c_x <= '0; query.vert_c_y <= '0; query.vert_c_z <= '0;
            send_gap   = 0;
            burst_mode = 1'b0;
        end
        else if (!query.valid || query_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                query.valid <= 1'b0;
            end
            else if (pending_queries.size() > queries_sent)
            begin
                query_t q;
                q = pending_queries[queries_sent];
                query.point_x <= q.p[0];  query.point_y <= q.p[1];  query.point_z <= q.p[2];
                query.vert_a_x <= q.a[0]; query.vert_a_y <= q.a[1]; query.vert_a_z <= q.a[2];
                query.vert_b_x <= q.b[0]; query.vert_b_y <= q.b[1]; query.vert_b_z <= q.b[2];
                query.vert_c_x <= q.c[0]; query.vert_c_y <= q.c[1]; query.vert_c_z <= q.c[2];
                query.valid <= 1'b1;
                if ($urandom_range(0, 99) == 0)
                    burst_mode = ~burst_mode;
                // keep offering during the long hold-off so the pipeline backs up
                send_gap = (burst_mode || long_hold) ? 0 : $urandom_range(0, 19);
            end
            else
                query.valid <= 1'b0;
        end
    end

    // Result receiver: random stalls plus one long hold-off
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (result_taken)
                recv_gap = burst_mode ? 0 : $urandom_range(0, 19);
            else if (recv_gap > 0)
                recv_gap--;
            result.ready <= (recv_gap == 0) && !long_hold;
        end
    end

    // Long hold-off so the pipeline fills and backs up
    initial
    begin
        long_hold = 1'b0;
        wait (queries_sent > 300);
        @(posedge clk);
        long_hold = 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
    end

    // Monitor: record query transfers, check result transfers
    always @(posedge clk)
    begin
        nearest_t got;
        nearest_t want;
        query_taken  = 1'b0;
        result_taken = 1'b0;
        if (rst_n && query.valid && query.ready)
        begin
            expected_points.push_back(nearest_on_triangle(pending_queries[queries_sent]));
            queries_sent++;
            query_taken = 1'b1;
        end
        if (rst_n && result.valid && result.ready)
        begin
            result_taken = 1'b1;
            results_seen++;
            got.near   = {result.near_z, result.near_y, result.near_x};
            got.region = region_t'(result.region);
            if (expected_points.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result %h region %0d", $time, got.near,
                         got.region);
            end
            else
            begin
                want = expected_points.pop_front();
                for (int i = 0; i < 3; i++)
                    if (got.near[i] !== want.near[i])
                    begin
                        error_count++;
                        $display("%0t: result %0d near[%0d] expected %h actual %h", $time,
                                 results_seen, i, want.near[i], got.near[i]);
                    end
                if (got.region !== want.region)
                begin
                    error_count++;
                    $display("%0t: result %0d region expected %0d actual %0d", $time,
                             results_seen, want.region, got.region);
                end
            end
        end
    end

endmodule
